>>> rtl/lzwd_pkg.sv
// Package for the LZW decoder: field widths, dictionary entry layout,
// sequencer states and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

  // Field widths fixed by the code format.
  localparam int CodeW      = 16;
  localparam int ByteW      = 8;
  localparam int LenW       = 7;
  localparam int StatusW    = 2;
  localparam int DictDepth  = 65536;
  localparam int MaxStrLen  = 64;
  localparam int StackDepth = MaxStrLen;
  localparam int StackAw    = $clog2(StackDepth);

  localparam logic [CodeW-1:0] FirstFree   = CodeW'(256);
  localparam logic [CodeW-1:0] LimitReset  = CodeW'(60000);
  localparam logic [LenW-1:0]  LenMax      = LenW'(MaxStrLen);
  localparam logic [LenW-1:0]  LenOverflow = LenW'(MaxStrLen + 1);

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusUnknown = 2'd1;
  localparam logic [StatusW-1:0] StatusTooLong = 2'd2;

  // One dictionary entry as stored in the dictionary memory.
  typedef struct packed {
    logic [CodeW-1:0] prefix;
    logic [ByteW-1:0] last_byte;
    logic [ByteW-1:0] first_byte;
    logic [LenW-1:0]  length;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RDPREV,
    S_RDCODE,
    S_FETCH,
    S_LEN,
    S_WALK,
    S_SRD,
    S_SOUT,
    S_ERR
  } state_t;

endpackage

`default_nettype wire

>>> rtl/lzwd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/lzw_decoder_16bit_core.sv
// LZW decoder for fixed 16-bit codes; depends on lzwd_pkg and lzwd_ram.
// For a string of len bytes (1..64), a code passes S_CHECK, S_RDPREV and S_RDCODE (these two
// only when an entry is added), S_FETCH, S_LEN, the prefix walk (one entry per cycle) and the
// stack drain (one byte per cycle while the output is not stalled); no new code is taken
// before the last byte is loaded. An unknown code or an over-long string ends in S_ERR.
// Reset (rst, synchronous) empties the stream and sets dict_limit to 60000.
`timescale 1ns / 1ps
`default_nettype none

module lzw_decoder_16bit_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write.
  input  wire logic                           cfg_wr_en,
  input  wire logic [lzwd_pkg::CodeW-1:0]     cfg_wr_data,
  // Code input channel.
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lzwd_pkg::CodeW-1:0]     code,
  input  wire logic                           end_of_stream,
  // Byte output channel.
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [lzwd_pkg::ByteW-1:0]     data_byte,
  output logic                                last_of_code,
  output logic      [lzwd_pkg::StatusW-1:0]   status
);

  lzwd_pkg::state_t state, state_next;

  // Control and stream registers.
  logic [lzwd_pkg::CodeW-1:0]   dict_limit;
  logic [lzwd_pkg::CodeW-1:0]   next_free;
  logic [lzwd_pkg::CodeW-1:0]   prev_code;
  logic                         prev_valid;
  // Per-code working registers.
  logic [lzwd_pkg::CodeW-1:0]   code_reg;
  logic                         eos_reg;
  logic                         adding;
  logic                         kwkwk;
  logic [lzwd_pkg::LenW-1:0]    prev_len;
  logic [lzwd_pkg::ByteW-1:0]   prev_first;
  logic [lzwd_pkg::LenW-1:0]    str_len;
  logic [lzwd_pkg::LenW-1:0]    walk_cnt;
  logic [lzwd_pkg::CodeW-1:0]   pos;
  logic [lzwd_pkg::StackAw-1:0] rd_idx;
  logic [lzwd_pkg::StatusW-1:0] err_status;

  // Memory ports.
  logic                          dict_we;
  logic [lzwd_pkg::CodeW-1:0]    dict_raddr;
  lzwd_pkg::entry_t              dict_wdata;
  lzwd_pkg::entry_t              dict_q;
  logic [lzwd_pkg::EntryW-1:0]   dict_rdata;
  logic                          stk_we;
  logic [lzwd_pkg::StackAw-1:0]  stk_waddr;
  logic [lzwd_pkg::ByteW-1:0]    stk_wdata;
  logic [lzwd_pkg::StackAw-1:0]  stk_raddr;
  logic [lzwd_pkg::ByteW-1:0]    stk_rdata;

  // Derived values.
  logic                          in_xfer;
  logic                          out_free;
  logic                          out_load;
  logic                          code_lit;
  logic                          prev_lit;
  logic                          pos_lit;
  logic                          can_add;
  logic                          known;
  logic [lzwd_pkg::LenW-1:0]     code_len;
  logic                          len_bad;
  logic [lzwd_pkg::CodeW-1:0]    pos_next;
  logic [lzwd_pkg::LenW-1:0]     walk_m1;
  logic [lzwd_pkg::LenW-1:0]     len_m1;
  logic                          byte_last;
  logic [lzwd_pkg::LenW:0]       new_len_sum;

  assign dict_q   = lzwd_pkg::entry_t'(dict_rdata);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Literal tests: codes below 256 are single bytes.
  assign code_lit = (code_reg[lzwd_pkg::CodeW-1:lzwd_pkg::ByteW] == '0);
  assign prev_lit = (prev_code[lzwd_pkg::CodeW-1:lzwd_pkg::ByteW] == '0);
  assign pos_lit  = (pos[lzwd_pkg::CodeW-1:lzwd_pkg::ByteW] == '0);

  // Dictionary grows only with a previous code and below the limit.
  assign can_add = prev_valid && (next_free < dict_limit);
  assign known   = code_lit || (code_reg < next_free) ||
                   (can_add && (code_reg == next_free));

  // Length of the current code's string, valid in S_LEN.
  assign code_len = code_lit ? lzwd_pkg::LenW'(1) : dict_q.length;
  assign len_bad  = (code_len == '0) || (code_len > lzwd_pkg::LenMax);

  // Prefix chain step.
  assign pos_next = pos_lit ? '0 : dict_q.prefix;
  assign walk_m1  = walk_cnt - lzwd_pkg::LenW'(1);
  assign len_m1   = str_len - lzwd_pkg::LenW'(1);
  assign byte_last = (rd_idx == len_m1[lzwd_pkg::StackAw-1:0]);

  // Length of a new entry, saturated one above the maximum string length.
  assign new_len_sum = {1'b0, prev_len} + (lzwd_pkg::LenW+1)'(1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      lzwd_pkg::S_IDLE: begin
        if (in_xfer) state_next = lzwd_pkg::S_CHECK;
      end
      lzwd_pkg::S_CHECK: begin
        if (!known)      state_next = lzwd_pkg::S_ERR;
        else if (can_add) state_next = lzwd_pkg::S_RDPREV;
        else             state_next = lzwd_pkg::S_FETCH;
      end
      lzwd_pkg::S_RDPREV: state_next = lzwd_pkg::S_RDCODE;
      lzwd_pkg::S_RDCODE: state_next = lzwd_pkg::S_FETCH;
      lzwd_pkg::S_FETCH:  state_next = lzwd_pkg::S_LEN;
      lzwd_pkg::S_LEN: begin
        if (len_bad) state_next = lzwd_pkg::S_ERR;
        else         state_next = lzwd_pkg::S_WALK;
      end
      lzwd_pkg::S_WALK: begin
        if (walk_cnt == lzwd_pkg::LenW'(1)) state_next = lzwd_pkg::S_SRD;
      end
      lzwd_pkg::S_SRD: state_next = lzwd_pkg::S_SOUT;
      lzwd_pkg::S_SOUT: begin
        if (out_free && byte_last) state_next = lzwd_pkg::S_IDLE;
      end
      lzwd_pkg::S_ERR: begin
        if (out_free) state_next = lzwd_pkg::S_IDLE;
      end
      default: state_next = lzwd_pkg::S_IDLE;
    endcase
  end

  // Output and memory control logic.
  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    dict_we    = 1'b0;
    dict_raddr = code_reg;
    dict_wdata = '{prefix:     prev_code,
                   last_byte:  kwkwk ? prev_first
                             : (code_lit ? code_reg[lzwd_pkg::ByteW-1:0]
                                         : dict_q.first_byte),
                   first_byte: prev_first,
                   length:     new_len_sum > (lzwd_pkg::LenW+1)'(lzwd_pkg::LenOverflow)
                             ? lzwd_pkg::LenOverflow : new_len_sum[lzwd_pkg::LenW-1:0]};
    stk_we     = 1'b0;
    stk_waddr  = walk_m1[lzwd_pkg::StackAw-1:0];
    stk_wdata  = pos_lit ? pos[lzwd_pkg::ByteW-1:0] : dict_q.last_byte;
    stk_raddr  = rd_idx;
    unique case (state)
      lzwd_pkg::S_IDLE:   in_ready = 1'b1;
      lzwd_pkg::S_CHECK:  dict_raddr = prev_code;
      lzwd_pkg::S_RDPREV: dict_raddr = code_reg;
      lzwd_pkg::S_RDCODE: dict_we = 1'b1;
      lzwd_pkg::S_FETCH,
      lzwd_pkg::S_LEN:    dict_raddr = code_reg;
      lzwd_pkg::S_WALK: begin
        stk_we     = 1'b1;
        dict_raddr = pos_next;
      end
      lzwd_pkg::S_SRD:    stk_raddr = rd_idx;
      lzwd_pkg::S_SOUT: begin
        out_load = out_free;
        if (out_free) stk_raddr = rd_idx + lzwd_pkg::StackAw'(1);
      end
      lzwd_pkg::S_ERR:    out_load = out_free;
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= lzwd_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst)            dict_limit <= lzwd_pkg::LimitReset;
    else if (cfg_wr_en) dict_limit <= cfg_wr_data;
  end

  // Stream state: grows on an added entry, resets on error or end of stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free  <= lzwd_pkg::FirstFree;
      prev_code  <= '0;
      prev_valid <= 1'b0;
    end else if (state == lzwd_pkg::S_ERR && out_free) begin
      next_free  <= lzwd_pkg::FirstFree;
      prev_code  <= '0;
      prev_valid <= 1'b0;
    end else if (state == lzwd_pkg::S_RDCODE) begin
      next_free  <= next_free + lzwd_pkg::CodeW'(1);
    end else if (state == lzwd_pkg::S_SOUT && out_free && byte_last) begin
      if (eos_reg) begin
        next_free  <= lzwd_pkg::FirstFree;
        prev_code  <= '0;
        prev_valid <= 1'b0;
      end else begin
        prev_code  <= code_reg;
        prev_valid <= 1'b1;
      end
    end
  end

  // Per-code working registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      code_reg <= code;
      eos_reg  <= end_of_stream;
    end
    if (state == lzwd_pkg::S_CHECK) begin
      adding     <= can_add;
      kwkwk      <= (code_reg == next_free);
      err_status <= lzwd_pkg::StatusUnknown;
    end
    if (state == lzwd_pkg::S_RDPREV) begin
      prev_len   <= prev_lit ? lzwd_pkg::LenW'(1) : dict_q.length;
      prev_first <= prev_lit ? prev_code[lzwd_pkg::ByteW-1:0] : dict_q.first_byte;
    end
    if (state == lzwd_pkg::S_LEN) begin
      str_len    <= code_len;
      walk_cnt   <= code_len;
      pos        <= code_reg;
      rd_idx     <= '0;
      err_status <= lzwd_pkg::StatusTooLong;
    end
    if (state == lzwd_pkg::S_WALK) begin
      walk_cnt <= walk_m1;
      pos      <= pos_next;
    end
    if (state == lzwd_pkg::S_SOUT && out_free) begin
      rd_idx <= rd_idx + lzwd_pkg::StackAw'(1);
    end
  end

  // Output register: holds one result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == lzwd_pkg::S_ERR) begin
        data_byte    <= '0;
        last_of_code <= 1'b1;
        status       <= err_status;
      end else begin
        data_byte    <= stk_rdata;
        last_of_code <= byte_last;
        status       <= lzwd_pkg::StatusOk;
      end
    end
  end

  // Dictionary memory, one entry per code.
  lzwd_ram #(
    .WIDTH(lzwd_pkg::EntryW),
    .DEPTH(lzwd_pkg::DictDepth)
  ) u_dict (
    .clk   (clk),
    .we    (dict_we && adding),
    .waddr (next_free),
    .wdata (dict_wdata),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  // Reversal stack for the bytes of one string.
  lzwd_ram #(
    .WIDTH(lzwd_pkg::ByteW),
    .DEPTH(lzwd_pkg::StackDepth)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

`default_nettype wire

>>> verif/lzw_decoder_16bit_core_tb.sv
// Self-checking testbench for lzw_decoder_16bit_core: a directed table of codes, then random
// LZW streams under several dictionary limits, each output byte checked against a typed result or a local decoder.
// Depends on lzwd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module lzw_decoder_16bit_core_tb;

  localparam int CycleLimit    = 1000000;
  localparam int IdleWait      = 200;
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 68;
  localparam int ChainLen      = 66;
  localparam int LongHold      = 500;

  // One output byte as the checker sees it.
  typedef struct packed {
    logic [lzwd_pkg::ByteW-1:0]   data_v;
    logic                         last_v;
    logic [lzwd_pkg::StatusW-1:0] status_v;
  } decoded_t;

  // One row of the directed table; the result is typed in only where typed_v is set.
  typedef struct packed {
    logic [lzwd_pkg::CodeW-1:0]   code_v;
    logic                         eos_v;
    logic                         typed_v;
    logic [lzwd_pkg::ByteW-1:0]   data_v;
    logic                         last_v;
    logic [lzwd_pkg::StatusW-1:0] status_v;
  } stim_row_t;

  typedef enum int {SinkFree, SinkRandom, SinkSparse, SinkBusy} sink_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [lzwd_pkg::CodeW-1:0]   cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [lzwd_pkg::CodeW-1:0]   code = '0;
  logic                         end_of_stream = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [lzwd_pkg::ByteW-1:0]   data_byte;
  logic                         last_of_code;
  logic [lzwd_pkg::StatusW-1:0] status;

  lzw_decoder_16bit_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code         (code),
    .end_of_stream(end_of_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .last_of_code (last_of_code),
    .status       (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the decoder: dictionary, stream state and limit register.
  logic [lzwd_pkg::CodeW-1:0] ent_prefix [lzwd_pkg::DictDepth];
  logic [lzwd_pkg::ByteW-1:0] ent_last   [lzwd_pkg::DictDepth];
  logic [lzwd_pkg::ByteW-1:0] ent_first  [lzwd_pkg::DictDepth];
  logic [lzwd_pkg::LenW-1:0]  ent_len    [lzwd_pkg::DictDepth];
  int unsigned                next_free_q;
  logic [lzwd_pkg::CodeW-1:0] prev_code;
  bit                         prev_ok;
  logic [lzwd_pkg::CodeW-1:0] dict_lim;

  decoded_t decoded_now [$];
  decoded_t pending_bytes [$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       chain_left = 0;
  bit       long_hold_req = 1'b0;

  // Directed codes, starting from reset with the default limit.
  stim_row_t dir_tab [0:20] = '{
    '{16'd65,    1'b0, 1'b1, 8'h41, 1'b1, lzwd_pkg::StatusOk}, // literal after reset
    '{16'd0,     1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk}, // lowest literal, first entry
    '{16'd255,   1'b0, 1'b1, 8'hff, 1'b1, lzwd_pkg::StatusOk}, // highest literal
    '{16'd256,   1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk}, // first dictionary entry
    '{16'd259,   1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk}, // code equal to next free entry
    '{16'd258,   1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk},
    '{16'd65535, 1'b0, 1'b1, 8'h00, 1'b1, lzwd_pkg::StatusUnknown}, // highest code, unknown
    '{16'd256,   1'b0, 1'b1, 8'h00, 1'b1, lzwd_pkg::StatusUnknown}, // next free, no previous
    '{16'd66,    1'b1, 1'b1, 8'h42, 1'b1, lzwd_pkg::StatusOk}, // end of stream
    '{16'd256,   1'b0, 1'b1, 8'h00, 1'b1, lzwd_pkg::StatusUnknown}, // emptied by end of stream
    '{16'd67,    1'b0, 1'b1, 8'h43, 1'b1, lzwd_pkg::StatusOk},
    '{16'd257,   1'b0, 1'b1, 8'h00, 1'b1, lzwd_pkg::StatusUnknown}, // one past next free entry
    '{16'd170,   1'b0, 1'b1, 8'haa, 1'b1, lzwd_pkg::StatusOk},
    '{16'd85,    1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk},
    '{16'd256,   1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk},
    '{16'd257,   1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk},
    '{16'd65535, 1'b1, 1'b1, 8'h00, 1'b1, lzwd_pkg::StatusUnknown}, // error with end of stream
    '{16'd128,   1'b0, 1'b1, 8'h80, 1'b1, lzwd_pkg::StatusOk},
    '{16'd1,     1'b0, 1'b0, 8'h00, 1'b0, lzwd_pkg::StatusOk},
    '{16'd32768, 1'b0, 1'b1, 8'h00, 1'b1, lzwd_pkg::StatusUnknown},
    '{16'd255,   1'b1, 1'b1, 8'hff, 1'b1, lzwd_pkg::StatusOk}
  };

  logic [lzwd_pkg::CodeW-1:0] phase_limits [NumPhases] = '{
    lzwd_pkg::LimitReset, 16'd256, 16'd258, 16'hffff, 16'd300, 16'd600, lzwd_pkg::LimitReset
  };

  function automatic void clear_stream();
    next_free_q = lzwd_pkg::FirstFree;
    prev_code = '0;
    prev_ok = 1'b0;
  endfunction

  function automatic int unsigned str_length(input logic [lzwd_pkg::CodeW-1:0] c);
    return (c < lzwd_pkg::FirstFree) ? 1 : ent_len[c];
  endfunction

  function automatic logic [lzwd_pkg::ByteW-1:0] str_head(input logic [lzwd_pkg::CodeW-1:0] c);
    return (c < lzwd_pkg::FirstFree) ? c[lzwd_pkg::ByteW-1:0] : ent_first[c];
  endfunction

  // Decode one code into decoded_now and update the dictionary.
  task automatic decode_code(input logic [lzwd_pkg::CodeW-1:0] c, input logic eos);
    int unsigned len, pos, e, nl;
    logic [lzwd_pkg::ByteW-1:0] fb;
    logic [lzwd_pkg::ByteW-1:0] rev [lzwd_pkg::MaxStrLen];
    bit known;
    decoded_now.delete();
    known = (c < lzwd_pkg::FirstFree) || (c < next_free_q) ||
            (prev_ok && c == next_free_q && next_free_q < dict_lim);
    if (!known) begin
      decoded_now.push_back(decoded_t'{8'h00, 1'b1, lzwd_pkg::StatusUnknown});
      clear_stream();
      return;
    end
    // Grow the dictionary by the previous string plus one byte.
    if (prev_ok && next_free_q < dict_lim) begin
      e = next_free_q;
      nl = str_length(prev_code) + 1;
      if (nl > lzwd_pkg::MaxStrLen + 1) nl = lzwd_pkg::MaxStrLen + 1;
      fb = (c == next_free_q) ? str_head(prev_code) : str_head(c);
      ent_prefix[e] = prev_code;
      ent_last[e] = fb;
      ent_first[e] = str_head(prev_code);
      ent_len[e] = lzwd_pkg::LenW'(nl);
      next_free_q++;
    end
    len = str_length(c);
    if (len == 0 || len > lzwd_pkg::MaxStrLen) begin
      decoded_now.push_back(decoded_t'{8'h00, 1'b1, lzwd_pkg::StatusTooLong});
      clear_stream();
      return;
    end
    // Walk the prefix chain backwards, then emit front to back.
    pos = c;
    for (int i = len; i > 0; i--) begin
      if (pos < lzwd_pkg::FirstFree) begin
        rev[i-1] = pos[lzwd_pkg::ByteW-1:0];
        pos = 0;
      end else begin
        rev[i-1] = ent_last[pos];
        pos = ent_prefix[pos];
      end
    end
    for (int i = 0; i < len; i++) begin
      decoded_now.push_back(decoded_t'{rev[i], (i + 1 == len), lzwd_pkg::StatusOk});
    end
    prev_code = c;
    prev_ok = 1'b1;
    if (eos) clear_stream();
  endtask

  // Mostly well-formed codes: dictionary hits, literals and the next free entry.
  // A chain repeats the next free entry for ChainLen codes or until the limit, so the string can grow too long.
  function automatic logic [lzwd_pkg::CodeW-1:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (chain_left > 0) begin
      chain_left--;
      if (!prev_ok) return lzwd_pkg::CodeW'($urandom_range(255));
      if (next_free_q < dict_lim) return lzwd_pkg::CodeW'(next_free_q);
      chain_left = 0;
    end
    if (r < 6) return lzwd_pkg::CodeW'($urandom);
    if (r < 16 && prev_ok) return lzwd_pkg::CodeW'(next_free_q);
    if (r < 55 && next_free_q > lzwd_pkg::FirstFree)
      return lzwd_pkg::CodeW'($urandom_range(next_free_q - 1, lzwd_pkg::FirstFree));
    return lzwd_pkg::CodeW'($urandom_range(255));
  endfunction

  // Offer one code in bursts with random gaps; predict its bytes once the transfer happens.
  task automatic send_code(input logic [lzwd_pkg::CodeW-1:0] c, input logic eos,
                           input logic use_typed, input decoded_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      burst_left = $urandom_range(16, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    code <= c;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    decode_code(c, eos);
    if (use_typed) pending_bytes.push_back(typed_res);
    else foreach (decoded_now[i]) pending_bytes.push_back(decoded_now[i]);
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic write_limit(input logic [lzwd_pkg::CodeW-1:0] v);
    in_valid <= 1'b0;
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dict_lim = v;
    burst_left = 0;
  endtask

  task automatic check_byte();
    decoded_t got, want;
    got = decoded_t'{data_byte, last_of_code, status};
    if (pending_bytes.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected byte: actual data %h last %b status %0d",
               $time, got.data_v, got.last_v, got.status_v);
    end else begin
      want = pending_bytes.pop_front();
      if (got !== want) begin
        fail_count++;
        $display({"%0t: byte mismatch: expected data %h last %b status %0d, ",
                  "actual data %h last %b status %0d"},
                 $time, want.data_v, want.last_v, want.status_v,
                 got.data_v, got.last_v, got.status_v);
      end
    end
  endtask

  // Output side: check each transfer, stall in changing modes, and hold off
  // for a long stretch when asked so the decoder backs up into its input.
  initial begin : byte_sink
    sink_mode_t mode;
    int mode_left;
    int hold_left;
    logic [1:0] tick;
    mode = SinkFree;
    mode_left = 0;
    hold_left = 0;
    tick = '0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_byte();
      if (long_hold_req) begin
        hold_left = LongHold;
        long_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(3));
        mode_left = $urandom_range(200, 32);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          SinkFree:   out_ready <= 1'b1;
          SinkRandom: out_ready <= 1'($urandom_range(1));
          SinkSparse: out_ready <= (tick == 2'd0);
          default:    out_ready <= (tick != 2'd0);
        endcase
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("lzw_decoder_16bit_core_tb failed");
      $finish;
    end
  end

  // Reset, directed table, then random streams under a series of limits.
  initial begin : code_source
    logic [lzwd_pkg::CodeW-1:0] lim;
    stim_row_t row;
    clear_stream();
    dict_lim = lzwd_pkg::LimitReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_code(row.code_v, row.eos_v, row.typed_v,
                decoded_t'{row.data_v, row.last_v, row.status_v});
    end

    for (int p = 0; p < NumPhases; p++) begin
      lim = phase_limits[p];
      if (p == 5) lim = lzwd_pkg::CodeW'($urandom_range(1024, 257));
      if (p > 0) write_limit(lim);
      if (p == 0) long_hold_req = 1'b1;
      if (p == 0 || p == 3) chain_left = ChainLen;
      repeat (ItemsPerPhase) begin
        send_code(pick_code(), ($urandom_range(49) == 0), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("lzw_decoder_16bit_core_tb passed");
    end else begin
      $display("lzw_decoder_16bit_core_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lzw_decoder_16bit_core.sv
verif/lzw_decoder_16bit_core_tb.sv
